// ----- rtl/fpbf_pkg.sv -----
// Shared types, codes and sizing constants of the best-fit partition allocator.
`default_nettype none

package fpbf_pkg;

  // Default sizing, handed to the top level parameters.
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_W_DEF     = 16;

  // Fixed widths of the counters reported in every result item.
  localparam int COUNT_W = 16;
  localparam int TOTAL_W = 20;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Configuration port geometry.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register indexes (byte address is four times the index).
  localparam logic [1:0] REG_MEMORY_SIZE      = 2'd0;
  localparam logic [1:0] REG_FIXED_MODE       = 2'd1;
  localparam logic [1:0] REG_FIXED_BLOCK_SIZE = 2'd2;

  // Input item kinds.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_FULL   = 2'd2,
    ST_CFGERR = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic request;
    logic check;
    logic div_step;
    logic scan_step;
    logic commit;
  } fpbf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_div;
    logic go_scan;
    logic div_done;
    logic scan_done;
    logic out_free;
  } fpbf_stat_t;

endpackage

`default_nettype wire

// ----- rtl/fpbf_if.sv -----
// Valid/ready channel interfaces for request items and result items.
`default_nettype none

interface fpbf_req_if #(
  parameter int SIZE_WIDTH = fpbf_pkg::SIZE_W_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [SIZE_WIDTH-1:0] size;

  modport source (output valid, output mode, output size, input ready);
  modport sink   (input valid, input mode, input size, output ready);
endinterface

interface fpbf_rsp_if #(
  parameter int SIZE_WIDTH = fpbf_pkg::SIZE_W_DEF,
  parameter int IDX_W      = 4
) ();
  import fpbf_pkg::*;

  logic                  valid;
  logic                  ready;
  status_t               status;
  logic [COUNT_W-1:0]    process_number;
  logic [IDX_W-1:0]      block_index;
  logic [SIZE_WIDTH-1:0] internal_fragment;
  logic [TOTAL_W-1:0]    total_internal;
  logic [SIZE_WIDTH-1:0] external_fragment;

  modport source (output valid, output status, output process_number, output block_index,
                  output internal_fragment, output total_internal,
                  output external_fragment, input ready);
  modport sink   (input valid, input status, input process_number, input block_index,
                  input internal_fragment, input total_internal,
                  input external_fragment, output ready);
endinterface

`default_nettype wire

// ----- rtl/fpbf_regs.sv -----
// APB-style configuration registers of the allocator.
`default_nettype none

module fpbf_regs #(
  parameter int SIZE_WIDTH = fpbf_pkg::SIZE_W_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fpbf_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [fpbf_pkg::CFG_DW-1:0]   pwdata,
  output logic      [fpbf_pkg::CFG_DW-1:0]   prdata,
  output logic                               pready,
  output logic      [SIZE_WIDTH-1:0]         memory_size,
  output logic                               fixed_mode,
  output logic      [SIZE_WIDTH-1:0]         fixed_block_size
);
  import fpbf_pkg::*;

  logic [SIZE_WIDTH-1:0] memory_size_r;
  logic                  fixed_mode_r;
  logic [SIZE_WIDTH-1:0] fixed_block_size_r;
  logic [1:0]            reg_idx;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel & penable & pwrite;

  // Register writes; writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      memory_size_r      <= '0;
      fixed_mode_r       <= 1'b0;
      fixed_block_size_r <= SIZE_WIDTH'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_MEMORY_SIZE:      memory_size_r      <= pwdata[SIZE_WIDTH-1:0];
        REG_FIXED_MODE:       fixed_mode_r       <= pwdata[0];
        REG_FIXED_BLOCK_SIZE: fixed_block_size_r <= pwdata[SIZE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      REG_MEMORY_SIZE:      prdata = CFG_DW'(memory_size_r);
      REG_FIXED_MODE:       prdata = CFG_DW'(fixed_mode_r);
      REG_FIXED_BLOCK_SIZE: prdata = CFG_DW'(fixed_block_size_r);
      default:              prdata = '0;
    endcase
  end

  assign memory_size      = memory_size_r;
  assign fixed_mode       = fixed_mode_r;
  assign fixed_block_size = fixed_block_size_r;

endmodule

`default_nettype wire

// ----- rtl/fpbf_ctrl.sv -----
// Controller state machine that sequences loads, checks, divides and scans.
`default_nettype none

module fpbf_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_mode,
  output logic                       in_ready,
  input  wire fpbf_pkg::fpbf_stat_t  stat,
  output fpbf_pkg::fpbf_cmd_t        cmd
);
  import fpbf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   accept;

  assign accept   = in_valid & in_ready_r;
  assign in_ready = in_ready_r;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_REQUEST) begin
            cmd.request = 1'b1;
            state_nxt   = S_CHECK;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.go_div) begin
          state_nxt = S_DIV;
        end else if (stat.go_scan) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered ready; the input stays closed during reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fpbf_dp.sv -----
// Datapath: block table, used flags, divider, best-fit scan and result register.
`default_nettype none

module fpbf_dp #(
  parameter int MAX_BLOCKS = fpbf_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_WIDTH = fpbf_pkg::SIZE_W_DEF,
  parameter int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire fpbf_pkg::fpbf_cmd_t             cmd,
  output fpbf_pkg::fpbf_stat_t                 stat,
  input  wire logic [SIZE_WIDTH-1:0]           in_size,
  input  wire logic [SIZE_WIDTH-1:0]           memory_size,
  input  wire logic                            fixed_mode,
  input  wire logic [SIZE_WIDTH-1:0]           fixed_block_size,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output fpbf_pkg::status_t                    out_status,
  output logic [fpbf_pkg::COUNT_W-1:0]         out_process_number,
  output logic [IDX_W-1:0]                     out_block_index,
  output logic [SIZE_WIDTH-1:0]                out_internal_fragment,
  output logic [fpbf_pkg::TOTAL_W-1:0]         out_total_internal,
  output logic [SIZE_WIDTH-1:0]                out_external_fragment
);
  import fpbf_pkg::*;

  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int SUM_W  = SIZE_WIDTH + CNT_W;
  localparam int DIVC_W = $clog2(SIZE_WIDTH + 1);
  localparam int CMP_W  = (SIZE_WIDTH > CNT_W) ? SIZE_WIDTH : CNT_W;
  localparam int TSUM_W = ((TOTAL_W > SIZE_WIDTH) ? TOTAL_W : SIZE_WIDTH) + 1;

  // Block table memory and its registered read port.
  logic [SIZE_WIDTH-1:0] block_table [MAX_BLOCKS];
  logic [SIZE_WIDTH-1:0] rd_data_r;

  // Bookkeeping state.
  logic [MAX_BLOCKS-1:0] used_r;
  logic [CNT_W-1:0]      loaded_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SIZE_WIDTH-1:0] alloc_r;
  logic [TOTAL_W-1:0]    total_r;
  logic [COUNT_W-1:0]    req_cnt_r;
  logic [SIZE_WIDTH-1:0] size_r;

  // Restoring divider.
  logic [SIZE_WIDTH-1:0] div_rem_r;
  logic [SIZE_WIDTH-1:0] div_quo_r;
  logic [DIVC_W-1:0]     div_cnt_r;
  logic [SIZE_WIDTH:0]   div_shift;
  logic                  div_ge;

  // Scan pipeline.
  logic [CNT_W-1:0]      scan_addr_r;
  logic                  cmp_v_r;
  logic [IDX_W-1:0]      cmp_idx_r;
  logic                  found_r;
  logic [SIZE_WIDTH-1:0] best_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [SIZE_WIDTH-1:0] slack;
  logic                  cand_fit;
  logic                  issue;

  // Output register.
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [COUNT_W-1:0]    out_pnum_r;
  logic [IDX_W-1:0]      out_idx_r;
  logic [SIZE_WIDTH-1:0] out_frag_r;
  logic [TOTAL_W-1:0]    out_total_r;
  logic [SIZE_WIDTH-1:0] out_ext_r;

  // Decision terms.
  logic                  bad_fixed;
  logic                  bad_var;
  logic                  full_var;
  logic                  full_fixed;
  logic                  fits_fixed;
  logic                  can_load;
  status_t               res_status;
  logic [IDX_W-1:0]      res_idx;
  logic [SIZE_WIDTH-1:0] res_frag;
  logic [SIZE_WIDTH-1:0] res_ext;
  logic                  res_alloc;
  logic                  res_mark;
  logic [TSUM_W-1:0]     tot_sum;
  logic [TOTAL_W-1:0]    total_nxt;

  assign bad_fixed  = (fixed_block_size == '0) || (fixed_block_size > memory_size);
  assign bad_var    = sum_r > SUM_W'(memory_size);
  assign full_var   = CMP_W'(alloc_r) >= CMP_W'(loaded_r);
  assign full_fixed = alloc_r >= div_quo_r;
  assign fits_fixed = size_r <= fixed_block_size;
  assign can_load   = loaded_r < CNT_W'(MAX_BLOCKS);

  // Status back to the controller.
  assign stat.go_div    = fixed_mode & ~bad_fixed;
  assign stat.go_scan   = ~fixed_mode & ~bad_var & ~full_var;
  assign stat.div_done  = (div_cnt_r == '0);
  assign stat.scan_done = (scan_addr_r == loaded_r) & ~cmp_v_r;
  assign stat.out_free  = ~out_valid_r | out_ready;

  // Table writes on load, registered reads during the scan.
  assign issue = cmd.scan_step & (scan_addr_r != loaded_r);

  always_ff @(posedge clk) begin
    if (cmd.load && can_load) begin
      block_table[loaded_r[IDX_W-1:0]] <= in_size;
    end
    if (issue) begin
      rd_data_r <= block_table[scan_addr_r[IDX_W-1:0]];
    end
  end

  // One quotient bit per cycle.
  assign div_shift = {div_rem_r, div_quo_r[SIZE_WIDTH-1]};
  assign div_ge    = div_shift >= {1'b0, fixed_block_size};

  // Candidate from the compare stage.
  assign cand_fit = ~used_r[cmp_idx_r] & (size_r <= rd_data_r);
  assign slack    = rd_data_r - size_r;

  // Outcome of the current request.
  always_comb begin
    res_status = ST_OK;
    res_idx    = '0;
    res_frag   = '0;
    res_ext    = '0;
    res_alloc  = 1'b0;
    res_mark   = 1'b0;
    if (fixed_mode) begin
      if (bad_fixed) begin
        res_status = ST_CFGERR;
      end else begin
        res_ext = div_rem_r;
        if (full_fixed) begin
          res_status = ST_FULL;
        end else if (fits_fixed) begin
          res_frag  = fixed_block_size - size_r;
          res_alloc = 1'b1;
        end else begin
          res_status = ST_NOFIT;
        end
      end
    end else begin
      if (bad_var) begin
        res_status = ST_CFGERR;
      end else begin
        res_ext = memory_size - sum_r[SIZE_WIDTH-1:0];
        if (full_var) begin
          res_status = ST_FULL;
        end else if (found_r) begin
          res_idx   = best_idx_r;
          res_frag  = best_r;
          res_alloc = 1'b1;
          res_mark  = 1'b1;
        end else begin
          res_status = ST_NOFIT;
        end
      end
    end
  end

  // Saturating running total of internal fragmentation.
  assign tot_sum   = TSUM_W'(total_r) + TSUM_W'(res_frag);
  assign total_nxt = (tot_sum > TSUM_W'(TOTAL_MAX)) ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      loaded_r    <= '0;
      sum_r       <= '0;
      alloc_r     <= '0;
      total_r     <= '0;
      req_cnt_r   <= '0;
      div_cnt_r   <= '0;
      scan_addr_r <= '0;
      cmp_v_r     <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Load one block size.
      if (cmd.load && can_load) begin
        used_r[loaded_r[IDX_W-1:0]] <= 1'b0;
        loaded_r <= loaded_r + CNT_W'(1);
        sum_r    <= sum_r + SUM_W'(in_size);
      end
      // Count the request.
      if (cmd.request && (req_cnt_r != COUNT_MAX)) begin
        req_cnt_r <= req_cnt_r + COUNT_W'(1);
      end
      // Arm the divider and the scan.
      if (cmd.check) begin
        div_cnt_r   <= DIVC_W'(SIZE_WIDTH);
        scan_addr_r <= '0;
        cmp_v_r     <= 1'b0;
        found_r     <= 1'b0;
      end
      if (cmd.div_step && (div_cnt_r != '0)) begin
        div_cnt_r <= div_cnt_r - DIVC_W'(1);
      end
      if (cmd.scan_step) begin
        cmp_v_r <= issue;
        if (issue) begin
          scan_addr_r <= scan_addr_r + CNT_W'(1);
        end
        if (cmp_v_r && cand_fit && (!found_r || (slack < best_r))) begin
          found_r <= 1'b1;
        end
      end
      // Commit the result.
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        total_r     <= total_nxt;
        if (res_alloc) begin
          alloc_r <= alloc_r + SIZE_WIDTH'(1);
        end
        if (res_mark) begin
          used_r[res_idx] <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.request) begin
      size_r <= in_size;
    end
    if (cmd.check) begin
      div_quo_r <= memory_size;
      div_rem_r <= '0;
    end else if (cmd.div_step && (div_cnt_r != '0)) begin
      div_quo_r <= {div_quo_r[SIZE_WIDTH-2:0], div_ge};
      div_rem_r <= div_ge ? SIZE_WIDTH'(div_shift - {1'b0, fixed_block_size})
                          : div_shift[SIZE_WIDTH-1:0];
    end
    if (issue) begin
      cmp_idx_r <= scan_addr_r[IDX_W-1:0];
    end
    if (cmd.scan_step && cmp_v_r && cand_fit && (!found_r || (slack < best_r))) begin
      best_r     <= slack;
      best_idx_r <= cmp_idx_r;
    end
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_pnum_r   <= req_cnt_r;
      out_idx_r    <= res_idx;
      out_frag_r   <= res_frag;
      out_total_r  <= total_nxt;
      out_ext_r    <= res_ext;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_process_number    = out_pnum_r;
  assign out_block_index       = out_idx_r;
  assign out_internal_fragment = out_frag_r;
  assign out_total_internal    = out_total_r;
  assign out_external_fragment = out_ext_r;

endmodule

`default_nettype wire

// ----- rtl/fixed_partition_best_fit_allocator.sv -----
// Top level of the best-fit partition allocator.
//
//   Channel   Direction  Handshake           Carries
//   in_item   sink       valid/ready         mode, size
//   out_item  source     valid/ready         status, process_number, block_index,
//                                            internal_fragment, total_internal,
//                                            external_fragment
//   cfg       APB slave  psel/penable/pready memory_size, fixed_mode, fixed_block_size
//
// A load item gives no result and the input stays ready for the next item. A request
// holds the input through accept, check and commit, plus the divider steps in fixed mode,
// or plus a scan of the loaded blocks in variable mode (one table read per cycle, then one
// compare stage to drain). A configuration error, or a full table in variable mode, skips
// both the divider and the scan.
// Reset is synchronous and active low; the input is not ready during reset and the
// block table needs no clearing.
// One result waits in the output register while the next item is accepted; a
// request's result is held back only while that register is still full.
`default_nettype none

module fixed_partition_best_fit_allocator #(
  parameter int MAX_BLOCKS = fpbf_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_WIDTH = fpbf_pkg::SIZE_W_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  fpbf_req_if.sink                         in_item,
  fpbf_rsp_if.source                       out_item,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fpbf_pkg::CFG_AW-1:0] paddr,
  input  wire logic [fpbf_pkg::CFG_DW-1:0] pwdata,
  output logic      [fpbf_pkg::CFG_DW-1:0] prdata,
  output logic                             pready
);
  import fpbf_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  logic [SIZE_WIDTH-1:0] memory_size;
  logic                  fixed_mode;
  logic [SIZE_WIDTH-1:0] fixed_block_size;
  fpbf_cmd_t             cmd;
  fpbf_stat_t            stat;

  // Configuration registers.
  fpbf_regs #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_regs (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .memory_size      (memory_size),
    .fixed_mode       (fixed_mode),
    .fixed_block_size (fixed_block_size)
  );

  // Sequencer.
  fpbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_mode  (in_item.mode),
    .in_ready (in_item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table, divider, scan and result register.
  fpbf_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH),
    .IDX_W      (IDX_W)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_size               (in_item.size),
    .memory_size           (memory_size),
    .fixed_mode            (fixed_mode),
    .fixed_block_size      (fixed_block_size),
    .out_ready             (out_item.ready),
    .out_valid             (out_item.valid),
    .out_status            (out_item.status),
    .out_process_number    (out_item.process_number),
    .out_block_index       (out_item.block_index),
    .out_internal_fragment (out_item.internal_fragment),
    .out_total_internal    (out_item.total_internal),
    .out_external_fragment (out_item.external_fragment)
  );

endmodule

`default_nettype wire

// ----- rtl/fpbf_checker.sv -----
// Port-level checks of the allocator's result channel, bound to the top level.
`default_nettype none

module fpbf_checker #(
  parameter int SIZE_WIDTH = fpbf_pkg::SIZE_W_DEF,
  parameter int IDX_W      = 4
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [1:0]                    out_status,
  input wire logic [fpbf_pkg::COUNT_W-1:0]  out_process_number,
  input wire logic [IDX_W-1:0]              out_block_index,
  input wire logic [SIZE_WIDTH-1:0]         out_internal_fragment,
  input wire logic [fpbf_pkg::TOTAL_W-1:0]  out_total_internal,
  input wire logic [SIZE_WIDTH-1:0]         out_external_fragment
);
  import fpbf_pkg::*;

  // A stalled result item stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_process_number)
      && $stable(out_block_index) && $stable(out_internal_fragment)
      && $stable(out_total_internal) && $stable(out_external_fragment))
    else $error("result payload changed while stalled");

  // Only an allocation reports a block and a slack.
  a_unalloc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_block_index == '0)
      && (out_internal_fragment == '0))
    else $error("block or slack reported without an allocation");

  // A configuration error reports no external fragmentation and a nonzero request count.
  a_cfgerr_ext: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_CFGERR) |-> (out_external_fragment == '0)
      && (out_process_number != '0))
    else $error("configuration error item carries stray fields");

endmodule

bind fixed_partition_best_fit_allocator fpbf_checker #(
  .SIZE_WIDTH (SIZE_WIDTH),
  .IDX_W      (IDX_W)
) u_fpbf_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_item.valid),
  .out_ready             (out_item.ready),
  .out_status            (out_item.status),
  .out_process_number    (out_item.process_number),
  .out_block_index       (out_item.block_index),
  .out_internal_fragment (out_item.internal_fragment),
  .out_total_internal    (out_item.total_internal),
  .out_external_fragment (out_item.external_fragment)
);

`default_nettype wire
